FILE: rtl/mpm_pkg.sv
package mpm_pkg;

  // Field and arithmetic widths.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int ZW         = FRAC_BITS + 4;          // Q4.28 word
  localparam int PW         = 2 * ZW;                 // exact Q8.56 product
  localparam int QW         = FRAC_BITS + 3;          // quotient magnitude, at most 2.0
  localparam int DIV_STEPS  = COORD_BITS + FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Escape bound 4.0 in Q8.56.
  localparam logic [PW-1:0] FOUR_Q56 = PW'(4) << (2 * FRAC_BITS);

  localparam logic [COORD_BITS-1:0] GRID_RESET = COORD_BITS'(255);

  localparam logic [7:0] PIX_INSIDE  = 8'd255;
  localparam logic [7:0] PIX_OUTSIDE = 8'd0;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EVEN  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
  } mpm_in_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [1:0] status;
  } mpm_out_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MS_RR,
    MS_II,
    MS_RI
  } mul_sel_t;

  // Controls from the sequencer to the iteration datapath.
  typedef struct packed {
    logic     clear;
    logic     mul_en;
    mul_sel_t sel;
    logic     upd_en;
  } iter_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_RE,
    S_DIV_IM,
    S_MRR,
    S_MII,
    S_MRI,
    S_ADD,
    S_DONE
  } state_t;

endpackage

FILE: rtl/mandelbrot_pixel_membership_core.sv
// Escape-time membership test for one pixel of an odd square grid. A pixel
// that passes the grid checks is mapped to c in Q4.28 by a restoring divider
// that produces one quotient bit per cycle, run once for each coordinate.
// Then z = z*z + c is iterated with a single shared 32x32 multiplier,
// each iteration being three product steps and one combine/test step. A
// pixel that escapes, or stays bounded up to ITER_LIMIT iterations, has its
// result loaded from the combine step into a result register; an even grid
// size or an out-of-range coordinate loads it at the transfer. From there the
// done state moves it to the output register and raises out_valid, waiting
// while a previous result is not taken. One pixel is processed at a
// time; in_ready is high only while idle, and the finished result waits in an
// output register until it is taken.
// grid_size is written through cfg_we/cfg_wdata and resets to 255.
module mandelbrot_pixel_membership_core #(
  parameter int ITER_LIMIT = 500
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mpm_pkg::mpm_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mpm_pkg::mpm_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [mpm_pkg::COORD_BITS-1:0]   cfg_wdata
);

  localparam int CB     = mpm_pkg::COORD_BITS;
  localparam int ZW     = mpm_pkg::ZW;
  localparam int ITER_W = $clog2(ITER_LIMIT + 1);

  mpm_pkg::state_t state_r, state_nxt;

  logic [CB-1:0]        grid_r;
  logic [CB-1:0]        col_mag_r;
  logic                 re_neg_r;
  logic                 im_neg_r;
  logic signed [ZW-1:0] cre_r;
  logic signed [ZW-1:0] cim_r;
  logic [ITER_W-1:0]    cnt_r;
  logic [7:0]           res_pix_r;
  logic [1:0]           res_st_r;
  logic                 out_valid_r;
  mpm_pkg::mpm_out_t    out_data_r;

  logic [CB-2:0]        center;
  logic                 row_neg;
  logic                 col_neg;
  logic [CB-1:0]        row_mag;
  logic [CB-1:0]        col_mag;
  logic                 div_start;
  logic [CB-1:0]        div_mag;
  logic                 div_done;
  logic [mpm_pkg::QW-1:0] div_quot;
  logic signed [ZW-1:0] q_pos;
  logic signed [ZW-1:0] coord;
  logic                 coord_neg;
  logic                 escape;
  mpm_pkg::iter_ctl_t   ictl;
  logic                 accept;
  logic                 cre_ld;
  logic                 cim_ld;
  logic                 cnt_clr;
  logic                 cnt_inc;
  logic                 res_ld;
  logic [7:0]           res_pix_nxt;
  logic [1:0]           res_st_nxt;
  logic                 out_ld;

  // Offsets of the pixel from the grid center, as sign and magnitude.
  always_comb begin
    center  = grid_r[CB-1:1];
    row_neg = (in_data.row < {1'b0, center});
    col_neg = (in_data.col < {1'b0, center});
    row_mag = row_neg ? ({1'b0, center} - in_data.row) : (in_data.row - {1'b0, center});
    col_mag = col_neg ? ({1'b0, center} - in_data.col) : (in_data.col - {1'b0, center});
  end

  // Signed coordinate from the unsigned quotient; a zero center maps to zero.
  always_comb begin
    coord_neg = (state_r == mpm_pkg::S_DIV_RE) ? re_neg_r : im_neg_r;
    q_pos     = $signed({1'b0, div_quot});
    if (center == '0) begin
      coord = '0;
    end else if (coord_neg) begin
      coord = -q_pos;
    end else begin
      coord = q_pos;
    end
  end

  assign in_ready = (state_r == mpm_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  // Sequencer: next state and control strobes.
  always_comb begin
    state_nxt   = state_r;
    div_start   = 1'b0;
    div_mag     = row_mag;
    ictl        = '{clear: 1'b0, mul_en: 1'b0, sel: mpm_pkg::MS_RR, upd_en: 1'b0};
    cre_ld      = 1'b0;
    cim_ld      = 1'b0;
    cnt_clr     = 1'b0;
    cnt_inc     = 1'b0;
    res_ld      = 1'b0;
    res_pix_nxt = mpm_pkg::PIX_OUTSIDE;
    res_st_nxt  = mpm_pkg::ST_OK;
    out_ld      = 1'b0;
    case (state_r)
      mpm_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!grid_r[0]) begin
            res_ld     = 1'b1;
            res_st_nxt = mpm_pkg::ST_EVEN;
            state_nxt  = mpm_pkg::S_DONE;
          end else if ((in_data.row >= grid_r) || (in_data.col >= grid_r)) begin
            res_ld     = 1'b1;
            res_st_nxt = mpm_pkg::ST_RANGE;
            state_nxt  = mpm_pkg::S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = mpm_pkg::S_DIV_RE;
          end
        end
      end
      mpm_pkg::S_DIV_RE: begin
        if (div_done) begin
          cre_ld    = 1'b1;
          div_start = 1'b1;
          div_mag   = col_mag_r;
          state_nxt = mpm_pkg::S_DIV_IM;
        end
      end
      mpm_pkg::S_DIV_IM: begin
        if (div_done) begin
          cim_ld     = 1'b1;
          ictl.clear = 1'b1;
          cnt_clr    = 1'b1;
          state_nxt  = mpm_pkg::S_MRR;
        end
      end
      mpm_pkg::S_MRR: begin
        ictl.mul_en = 1'b1;
        ictl.sel    = mpm_pkg::MS_RR;
        state_nxt   = mpm_pkg::S_MII;
      end
      mpm_pkg::S_MII: begin
        ictl.mul_en = 1'b1;
        ictl.sel    = mpm_pkg::MS_II;
        state_nxt   = mpm_pkg::S_MRI;
      end
      mpm_pkg::S_MRI: begin
        ictl.mul_en = 1'b1;
        ictl.sel    = mpm_pkg::MS_RI;
        state_nxt   = mpm_pkg::S_ADD;
      end
      mpm_pkg::S_ADD: begin
        // The test sees z from the previous update; z = 0 never escapes.
        if (escape) begin
          res_ld    = 1'b1;
          state_nxt = mpm_pkg::S_DONE;
        end else if (cnt_r == ITER_W'(ITER_LIMIT)) begin
          res_ld      = 1'b1;
          res_pix_nxt = mpm_pkg::PIX_INSIDE;
          state_nxt   = mpm_pkg::S_DONE;
        end else begin
          ictl.upd_en = 1'b1;
          cnt_inc     = 1'b1;
          state_nxt   = mpm_pkg::S_MRR;
        end
      end
      mpm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_ld    = 1'b1;
          state_nxt = mpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mpm_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpm_pkg::S_IDLE;
      grid_r      <= mpm_pkg::GRID_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        grid_r <= cfg_wdata;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cnt_clr) begin
        cnt_r <= '0;
      end else if (cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      col_mag_r <= col_mag;
      re_neg_r  <= row_neg;
      im_neg_r  <= col_neg;
    end
    if (cre_ld) begin
      cre_r <= coord;
    end
    if (cim_ld) begin
      cim_r <= coord;
    end
    if (res_ld) begin
      res_pix_r <= res_pix_nxt;
      res_st_r  <= res_st_nxt;
    end
    if (out_ld) begin
      out_data_r.pixel_value <= res_pix_r;
      out_data_r.status      <= res_st_r;
    end
  end

  mpm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (div_mag),
    .den     (center),
    .done    (div_done),
    .quot    (div_quot)
  );

  mpm_iter u_iter (
    .clk    (clk),
    .ctl    (ictl),
    .cre    (cre_r),
    .cim    (cim_r),
    .escape (escape)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/mpm_div.sv
// Restoring divider, one quotient bit per cycle.
// Computes floor((num_mag << (FRAC_BITS+1)) / den) where the quotient is known
// to fit QW bits because num_mag never exceeds den.
module mpm_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [mpm_pkg::COORD_BITS-1:0]   num_mag,
  input  logic [mpm_pkg::COORD_BITS-2:0]   den,
  output logic                             done,
  output logic [mpm_pkg::QW-1:0]           quot
);

  localparam int CB = mpm_pkg::COORD_BITS;
  localparam int DW = mpm_pkg::DIV_STEPS;
  localparam int QW = mpm_pkg::QW;
  localparam int CW = mpm_pkg::DIV_CNT_W;

  logic [DW-1:0]                  dvd_r;
  logic [CB-2:0]                  rem_r;
  logic [CB-2:0]                  den_r;
  logic [QW-1:0]                  quo_r;
  logic [CW-1:0]                  cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [CB-1:0] trial;
  logic [CB-1:0] diff;
  logic          ge;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // Control state of the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out MSB first, quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num_mag, (DW - CB)'(0)};
      rem_r <= '0;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= ge ? diff[CB-2:0] : trial[CB-2:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: rtl/mpm_iter.sv
// Escape-time datapath: one shared signed multiplier forms re*re, im*im and
// re*im in turn; the combine step then tests the magnitude and updates z.
module mpm_iter (
  input  logic                                clk,
  input  mpm_pkg::iter_ctl_t                  ctl,
  input  logic signed [mpm_pkg::ZW-1:0]       cre,
  input  logic signed [mpm_pkg::ZW-1:0]       cim,
  output logic                                escape
);

  localparam int ZW = mpm_pkg::ZW;
  localparam int PW = mpm_pkg::PW;
  localparam int FB = mpm_pkg::FRAC_BITS;

  logic signed [ZW-1:0] zre_r;
  logic signed [ZW-1:0] zim_r;
  logic signed [PW-1:0] rr_r;
  logic signed [PW-1:0] ii_r;
  logic signed [PW-1:0] ri_r;

  logic signed [ZW-1:0] mul_a;
  logic signed [ZW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic        [PW-1:0] mag;
  logic signed [PW-1:0] sq_re;
  logic signed [ZW-1:0] nre;
  logic signed [ZW-1:0] nim;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctl.sel)
      mpm_pkg::MS_RR: begin
        mul_a = zre_r;
        mul_b = zre_r;
      end
      mpm_pkg::MS_II: begin
        mul_a = zim_r;
        mul_b = zim_r;
      end
      mpm_pkg::MS_RI: begin
        mul_a = zre_r;
        mul_b = zim_r;
      end
      default: begin
        mul_a = zre_r;
        mul_b = zre_r;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  // Products are kept exact in Q8.56.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      case (ctl.sel)
        mpm_pkg::MS_RR: rr_r <= prod;
        mpm_pkg::MS_II: ii_r <= prod;
        mpm_pkg::MS_RI: ri_r <= prod;
        default:        rr_r <= prod;
      endcase
    end
  end

  // Magnitude test on the current z and the next z, rounded down to Q4.28.
  always_comb begin
    mag    = $unsigned(rr_r) + $unsigned(ii_r);
    escape = (mag >= mpm_pkg::FOUR_Q56);
    sq_re  = rr_r - ii_r;
    nre    = $signed(sq_re[FB+ZW-1:FB]) + cre;
    nim    = $signed(ri_r[FB+ZW-2:FB-1]) + cim;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      zre_r <= '0;
      zim_r <= '0;
    end else if (ctl.upd_en) begin
      zre_r <= nre;
      zim_r <= nim;
    end
  end

endmodule

FILE: rtl/mpm_checker.sv
// Port-level checks for the membership core.
module mpm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input mpm_pkg::mpm_out_t              out_data,
  input logic                           cfg_we,
  input logic [mpm_pkg::COORD_BITS-1:0] cfg_wdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // After a transfer the core is busy with that pixel.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // Any error status carries an outside pixel.
  a_err_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != mpm_pkg::ST_OK) |->
      out_data.pixel_value == mpm_pkg::PIX_OUTSIDE)
    else $error("error status with nonzero pixel");

  // The pixel value is one of the two levels.
  a_pixel_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_value == mpm_pkg::PIX_OUTSIDE) ||
                  (out_data.pixel_value == mpm_pkg::PIX_INSIDE))
    else $error("pixel value outside the two levels");

  // The grid size is only written with known data while the core is idle and empty.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_ready && !out_valid && !$isunknown(cfg_wdata))
    else $error("grid size written while a pixel is in flight");

endmodule

bind mandelbrot_pixel_membership_core mpm_checker u_mpm_checker (.*);
